/* rtl/core/mice_pkg.sv */
`default_nettype none

package mice_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned STIFF_W    = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned POS_BITS   = 16;
  localparam int unsigned SMALL_BITS = 12;
  localparam int unsigned FRAME_W    = 64;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned CMD_W      = 3;

  localparam int unsigned NUM_VALUES = 5;
  localparam int unsigned VAL_IDX_W  = 3;
  localparam int unsigned DIV_STEPS  = POS_BITS;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned SCALED_W   = DATA_W + POS_BITS;

  localparam logic [VAL_IDX_W-1:0] VAL_POS    = 3'd0;
  localparam logic [VAL_IDX_W-1:0] VAL_SPEED  = 3'd1;
  localparam logic [VAL_IDX_W-1:0] VAL_STIFF  = 3'd2;
  localparam logic [VAL_IDX_W-1:0] VAL_DAMP   = 3'd3;
  localparam logic [VAL_IDX_W-1:0] VAL_TORQUE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_MAX   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STIFF_MAX    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMP_MAX     = 3'd7;

  localparam logic signed [DATA_W-1:0] RST_POSITION_MIN = -32'sd819200;
  localparam logic signed [DATA_W-1:0] RST_POSITION_MAX = 32'sd819200;
  localparam logic signed [DATA_W-1:0] RST_SPEED_MIN    = -32'sd3276800;
  localparam logic signed [DATA_W-1:0] RST_SPEED_MAX    = 32'sd3276800;
  localparam logic signed [DATA_W-1:0] RST_TORQUE_MIN   = -32'sd1179648;
  localparam logic signed [DATA_W-1:0] RST_TORQUE_MAX   = 32'sd1179648;
  localparam logic [STIFF_W-1:0]       RST_STIFF_MAX    = 31'd32768000;
  localparam logic [STIFF_W-1:0]       RST_DAMP_MAX     = 31'd327680;

  localparam logic [FRAME_W-1:0] FRAME_ENTER = 64'hFFFF_FFFF_FFFF_FFFC;
  localparam logic [FRAME_W-1:0] FRAME_EXIT  = 64'hFFFF_FFFF_FFFF_FFFD;
  localparam logic [FRAME_W-1:0] FRAME_ZERO  = 64'hFFFF_FFFF_FFFF_FFFE;

  typedef enum logic [CMD_W-1:0] {
    CMD_RAW      = 3'd0,
    CMD_TORQUE   = 3'd1,
    CMD_SPEED    = 3'd2,
    CMD_POSITION = 3'd3,
    CMD_MIXED    = 3'd4,
    CMD_ENTER    = 3'd5,
    CMD_EXIT     = 3'd6,
    CMD_SET_ZERO = 3'd7
  } cmd_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_EXIT     = 3'd0,
    MODE_ENTER    = 3'd1,
    MODE_TORQUE   = 3'd2,
    MODE_SPEED    = 3'd3,
    MODE_POSITION = 3'd4,
    MODE_MIXED    = 3'd5,
    MODE_WARNING  = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    KIND_ENCODED,
    KIND_ENTER,
    KIND_EXIT,
    KIND_ZERO,
    KIND_REFUSED
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_DIFF,
    ST_SCALE,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] torque_value;
    logic signed [DATA_W-1:0] speed_value;
    logic signed [DATA_W-1:0] position_value;
    logic signed [DATA_W-1:0] stiffness_value;
    logic signed [DATA_W-1:0] damping_value;
  } in_word_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               frame_valid;
    logic               last;
    logic [MODE_W-1:0]  mode_now;
  } out_word_t;

  typedef struct packed {
    logic                  load;
    logic [NUM_VALUES-1:0] val_mask;
    logic                  clamp;
    logic                  diff;
    logic                  scale;
    logic                  div_step;
    logic                  div_last;
    logic [VAL_IDX_W-1:0]  idx;
    logic                  emit;
    kind_t                 kind;
    logic                  last;
    mode_t                 mode;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  function automatic logic [NUM_VALUES-1:0] value_mask(input cmd_t c);
    logic [NUM_VALUES-1:0] m;
    m = '0;
    case (c)
      CMD_RAW: begin
        m = '1;
      end
      CMD_TORQUE: begin
        m[VAL_TORQUE] = 1'b1;
      end
      CMD_SPEED: begin
        m[VAL_SPEED] = 1'b1;
        m[VAL_DAMP]  = 1'b1;
      end
      CMD_POSITION: begin
        m[VAL_POS]   = 1'b1;
        m[VAL_STIFF] = 1'b1;
      end
      CMD_MIXED: begin
        m[VAL_POS]   = 1'b1;
        m[VAL_SPEED] = 1'b1;
        m[VAL_STIFF] = 1'b1;
        m[VAL_DAMP]  = 1'b1;
      end
      default: begin
        m = '0;
      end
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/motor_impedance_command_encoder.sv */
`default_nettype none

// Impedance command encoder: takes one command word with five Q15.16 requests
// and returns one or two 64-bit motor frames. Raw, torque, speed, position and
// mixed commands clamp each value to its limit registers and quantize it with a
// single shared 16-step restoring divider, one value after another; each value
// passes through the clamp, diff, scale and divide states in turn, and no new
// command is taken until the result is loaded into the output register. Enter
// goes from accept to the emit state, which loads its fixed word, and then it
// encodes the zero word. Exit, set zero and refused motion commands go from
// accept to the emit state, which loads their word. One output register holds
// the result, so a new command is taken while the last word still waits. Write
// the limit registers only while no command is in flight.
module motor_impedance_command_encoder (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire mice_pkg::in_word_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output mice_pkg::out_word_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [mice_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mice_pkg::DATA_W-1:0]     cfg_wdata
);

  mice_pkg::dp_cmd_t  dp_cmd;
  mice_pkg::dp_stat_t dp_stat;

  mice_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (mice_pkg::cmd_t'(in_data.cmd)),
    .in_ready (in_ready),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat)
  );

  mice_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a command is in flight");

  a_refused_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.frame_valid |->
      out_data.frame == '0 && out_data.last &&
      out_data.mode_now == mice_pkg::MODE_WARNING)
    else $error("refused word malformed");

  a_first_of_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |->
      out_data.frame == mice_pkg::FRAME_ENTER &&
      out_data.mode_now == mice_pkg::MODE_ENTER)
    else $error("non-final word is not the enter frame");

  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.emit |-> dp_stat.out_free)
    else $error("output register overwritten");
`endif

endmodule

`default_nettype wire

/* rtl/core/mice_ctrl.sv */
`default_nettype none

module mice_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire mice_pkg::cmd_t    in_cmd,
  output logic                   in_ready,
  output mice_pkg::dp_cmd_t      dp_cmd,
  input  wire mice_pkg::dp_stat_t dp_stat
);

  mice_pkg::state_t                       state_r, state_nxt;
  mice_pkg::mode_t                        mode_r, mode_nxt;
  mice_pkg::kind_t                        kind_r, kind_nxt;
  logic                                   last_r, last_nxt;
  logic                                   enc_after_r, enc_after_nxt;
  logic [mice_pkg::VAL_IDX_W-1:0]         idx_r, idx_nxt;
  logic [mice_pkg::CNT_W-1:0]             cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mice_pkg::ST_IDLE;
      mode_r      <= mice_pkg::MODE_EXIT;
      kind_r      <= mice_pkg::KIND_ENCODED;
      last_r      <= 1'b1;
      enc_after_r <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      kind_r      <= kind_nxt;
      last_r      <= last_nxt;
      enc_after_r <= enc_after_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    kind_nxt      = kind_r;
    last_nxt      = last_r;
    enc_after_nxt = enc_after_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    in_ready      = 1'b0;

    dp_cmd          = '0;
    dp_cmd.idx      = idx_r;
    dp_cmd.kind     = kind_r;
    dp_cmd.last     = last_r;
    dp_cmd.mode     = mode_r;

    unique case (state_r)
      mice_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.load     = 1'b1;
          dp_cmd.val_mask = mice_pkg::value_mask(in_cmd);
          idx_nxt         = '0;
          last_nxt        = 1'b1;
          enc_after_nxt   = 1'b0;
          unique case (in_cmd) inside
            mice_pkg::CMD_RAW: begin
              kind_nxt  = mice_pkg::KIND_ENCODED;
              state_nxt = mice_pkg::ST_CLAMP;
            end
            mice_pkg::CMD_ENTER: begin
              mode_nxt      = mice_pkg::MODE_ENTER;
              kind_nxt      = mice_pkg::KIND_ENTER;
              last_nxt      = 1'b0;
              enc_after_nxt = 1'b1;
              state_nxt     = mice_pkg::ST_EMIT;
            end
            mice_pkg::CMD_EXIT: begin
              mode_nxt  = mice_pkg::MODE_EXIT;
              kind_nxt  = mice_pkg::KIND_EXIT;
              state_nxt = mice_pkg::ST_EMIT;
            end
            mice_pkg::CMD_SET_ZERO: begin
              kind_nxt  = mice_pkg::KIND_ZERO;
              state_nxt = mice_pkg::ST_EMIT;
            end
            mice_pkg::CMD_TORQUE, mice_pkg::CMD_SPEED,
            mice_pkg::CMD_POSITION, mice_pkg::CMD_MIXED: begin
              if (mode_r == mice_pkg::MODE_EXIT) begin
                mode_nxt  = mice_pkg::MODE_WARNING;
                kind_nxt  = mice_pkg::KIND_REFUSED;
                state_nxt = mice_pkg::ST_EMIT;
              end else begin
                unique case (in_cmd)
                  mice_pkg::CMD_TORQUE:   mode_nxt = mice_pkg::MODE_TORQUE;
                  mice_pkg::CMD_SPEED:    mode_nxt = mice_pkg::MODE_SPEED;
                  mice_pkg::CMD_POSITION: mode_nxt = mice_pkg::MODE_POSITION;
                  default:                mode_nxt = mice_pkg::MODE_MIXED;
                endcase
                kind_nxt  = mice_pkg::KIND_ENCODED;
                state_nxt = mice_pkg::ST_CLAMP;
              end
            end
            default: begin
              state_nxt = mice_pkg::ST_IDLE;
            end
          endcase
        end
      end
      mice_pkg::ST_CLAMP: begin
        dp_cmd.clamp = 1'b1;
        state_nxt    = mice_pkg::ST_DIFF;
      end
      mice_pkg::ST_DIFF: begin
        dp_cmd.diff = 1'b1;
        state_nxt   = mice_pkg::ST_SCALE;
      end
      mice_pkg::ST_SCALE: begin
        dp_cmd.scale = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = mice_pkg::ST_DIV;
      end
      mice_pkg::ST_DIV: begin
        dp_cmd.div_step = 1'b1;
        cnt_nxt         = cnt_r + mice_pkg::CNT_W'(1);
        if (cnt_r == mice_pkg::CNT_W'(mice_pkg::DIV_STEPS - 1)) begin
          dp_cmd.div_last = 1'b1;
          if (idx_r == mice_pkg::VAL_IDX_W'(mice_pkg::NUM_VALUES - 1)) begin
            state_nxt = mice_pkg::ST_EMIT;
          end else begin
            idx_nxt   = idx_r + mice_pkg::VAL_IDX_W'(1);
            state_nxt = mice_pkg::ST_CLAMP;
          end
        end
      end
      mice_pkg::ST_EMIT: begin
        if (dp_stat.out_free) begin
          dp_cmd.emit = 1'b1;
          if (enc_after_r) begin
            enc_after_nxt = 1'b0;
            kind_nxt      = mice_pkg::KIND_ENCODED;
            last_nxt      = 1'b1;
            idx_nxt       = '0;
            state_nxt     = mice_pkg::ST_CLAMP;
          end else begin
            state_nxt = mice_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = mice_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/mice_dp.sv */
`default_nettype none

module mice_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire mice_pkg::in_word_t              in_data,
  input  wire logic                            cfg_we,
  input  wire logic [mice_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mice_pkg::DATA_W-1:0]     cfg_wdata,
  input  wire mice_pkg::dp_cmd_t               dp_cmd,
  output mice_pkg::dp_stat_t                   dp_stat,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output mice_pkg::out_word_t                  out_data
);

  localparam int unsigned DW  = mice_pkg::DATA_W;
  localparam int unsigned XW  = mice_pkg::DATA_W + 1;
  localparam int unsigned PB  = mice_pkg::POS_BITS;
  localparam int unsigned SB  = mice_pkg::SMALL_BITS;
  localparam int unsigned SW  = mice_pkg::SCALED_W;

  logic signed [DW-1:0]             pos_min_r, pos_max_r;
  logic signed [DW-1:0]             speed_min_r, speed_max_r;
  logic signed [DW-1:0]             torque_min_r, torque_max_r;
  logic [mice_pkg::STIFF_W-1:0]     stiff_max_r, damp_max_r;

  logic signed [DW-1:0]             vals_r [mice_pkg::NUM_VALUES];
  logic [PB-1:0]                    code_r [mice_pkg::NUM_VALUES];

  logic signed [XW-1:0]             sel_x, sel_lo, sel_hi;
  logic signed [XW-1:0]             x_low, x_clamp, span;
  logic signed [XW-1:0]             xc_r, lo_r;
  logic [DW-1:0]                    span_r;
  logic                             span_ok_r;
  logic                             wide_r;
  logic signed [XW-1:0]             diff_full;
  logic [DW-1:0]                    diff_r;
  logic [SW-1:0]                    scaled;
  logic [DW-1:0]                    rem_r, rem_nxt;
  logic [PB-1:0]                    quo_r, quo_nxt;
  logic [XW-1:0]                    trial;
  logic                             qbit;
  logic [mice_pkg::FRAME_W-1:0]     enc_frame;

  logic                             out_valid_r;
  mice_pkg::out_word_t              out_word_r, out_word_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_min_r    <= mice_pkg::RST_POSITION_MIN;
      pos_max_r    <= mice_pkg::RST_POSITION_MAX;
      speed_min_r  <= mice_pkg::RST_SPEED_MIN;
      speed_max_r  <= mice_pkg::RST_SPEED_MAX;
      torque_min_r <= mice_pkg::RST_TORQUE_MIN;
      torque_max_r <= mice_pkg::RST_TORQUE_MAX;
      stiff_max_r  <= mice_pkg::RST_STIFF_MAX;
      damp_max_r   <= mice_pkg::RST_DAMP_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mice_pkg::CFG_POSITION_MIN: pos_min_r    <= cfg_wdata;
        mice_pkg::CFG_POSITION_MAX: pos_max_r    <= cfg_wdata;
        mice_pkg::CFG_SPEED_MIN:    speed_min_r  <= cfg_wdata;
        mice_pkg::CFG_SPEED_MAX:    speed_max_r  <= cfg_wdata;
        mice_pkg::CFG_TORQUE_MIN:   torque_min_r <= cfg_wdata;
        mice_pkg::CFG_TORQUE_MAX:   torque_max_r <= cfg_wdata;
        mice_pkg::CFG_STIFF_MAX:    stiff_max_r  <= cfg_wdata[mice_pkg::STIFF_W-1:0];
        mice_pkg::CFG_DAMP_MAX:     damp_max_r   <= cfg_wdata[mice_pkg::STIFF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // zero the values that the command leaves unused
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      vals_r[mice_pkg::VAL_POS]    <= dp_cmd.val_mask[mice_pkg::VAL_POS] ?
                                      in_data.position_value : '0;
      vals_r[mice_pkg::VAL_SPEED]  <= dp_cmd.val_mask[mice_pkg::VAL_SPEED] ?
                                      in_data.speed_value : '0;
      vals_r[mice_pkg::VAL_STIFF]  <= dp_cmd.val_mask[mice_pkg::VAL_STIFF] ?
                                      in_data.stiffness_value : '0;
      vals_r[mice_pkg::VAL_DAMP]   <= dp_cmd.val_mask[mice_pkg::VAL_DAMP] ?
                                      in_data.damping_value : '0;
      vals_r[mice_pkg::VAL_TORQUE] <= dp_cmd.val_mask[mice_pkg::VAL_TORQUE] ?
                                      in_data.torque_value : '0;
    end
  end

  always_comb begin
    unique case (dp_cmd.idx)
      mice_pkg::VAL_POS: begin
        sel_x  = XW'(vals_r[mice_pkg::VAL_POS]);
        sel_lo = XW'(pos_min_r);
        sel_hi = XW'(pos_max_r);
      end
      mice_pkg::VAL_SPEED: begin
        sel_x  = XW'(vals_r[mice_pkg::VAL_SPEED]);
        sel_lo = XW'(speed_min_r);
        sel_hi = XW'(speed_max_r);
      end
      mice_pkg::VAL_STIFF: begin
        sel_x  = XW'(vals_r[mice_pkg::VAL_STIFF]);
        sel_lo = '0;
        sel_hi = {2'b00, stiff_max_r};
      end
      mice_pkg::VAL_DAMP: begin
        sel_x  = XW'(vals_r[mice_pkg::VAL_DAMP]);
        sel_lo = '0;
        sel_hi = {2'b00, damp_max_r};
      end
      default: begin
        sel_x  = XW'(vals_r[mice_pkg::VAL_TORQUE]);
        sel_lo = XW'(torque_min_r);
        sel_hi = XW'(torque_max_r);
      end
    endcase
  end

  assign x_low   = (sel_x < sel_lo) ? sel_lo : sel_x;
  assign x_clamp = (x_low > sel_hi) ? sel_hi : x_low;
  assign span    = sel_hi - sel_lo;

  assign diff_full = xc_r - lo_r;

  assign scaled = wide_r ?
                  ({diff_r, {PB{1'b0}}} - {{PB{1'b0}}, diff_r}) :
                  ({{(PB - SB){1'b0}}, diff_r, {SB{1'b0}}} - {{PB{1'b0}}, diff_r});

  // restoring divide: one quotient bit per step
  assign trial   = {rem_r, quo_r[PB-1]} - {1'b0, span_r};
  assign qbit    = ~trial[XW-1];
  assign rem_nxt = qbit ? trial[DW-1:0] : {rem_r[DW-2:0], quo_r[PB-1]};
  assign quo_nxt = {quo_r[PB-2:0], qbit};

  always_ff @(posedge clk) begin
    if (dp_cmd.clamp) begin
      xc_r      <= x_clamp;
      lo_r      <= sel_lo;
      span_r    <= span[DW-1:0];
      span_ok_r <= (span > XW'(0));
      wide_r    <= (dp_cmd.idx == mice_pkg::VAL_POS);
    end
    if (dp_cmd.diff) begin
      diff_r <= diff_full[DW-1:0];
    end
    if (dp_cmd.scale) begin
      rem_r <= scaled[SW-1:PB];
      quo_r <= scaled[PB-1:0];
    end else if (dp_cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (dp_cmd.div_last) begin
      code_r[dp_cmd.idx] <= span_ok_r ? quo_nxt : '0;
    end
  end

  assign enc_frame = {code_r[mice_pkg::VAL_POS],
                      code_r[mice_pkg::VAL_SPEED][SB-1:0],
                      code_r[mice_pkg::VAL_STIFF][SB-1:0],
                      code_r[mice_pkg::VAL_DAMP][SB-1:0],
                      code_r[mice_pkg::VAL_TORQUE][SB-1:0]};

  always_comb begin
    out_word_nxt.frame_valid = 1'b1;
    out_word_nxt.last        = dp_cmd.last;
    out_word_nxt.mode_now    = dp_cmd.mode;
    unique case (dp_cmd.kind)
      mice_pkg::KIND_ENCODED: out_word_nxt.frame = enc_frame;
      mice_pkg::KIND_ENTER:   out_word_nxt.frame = mice_pkg::FRAME_ENTER;
      mice_pkg::KIND_EXIT:    out_word_nxt.frame = mice_pkg::FRAME_EXIT;
      mice_pkg::KIND_ZERO:    out_word_nxt.frame = mice_pkg::FRAME_ZERO;
      default: begin
        out_word_nxt.frame       = '0;
        out_word_nxt.frame_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dp_cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.emit) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign dp_stat.out_free = ~out_valid_r | out_ready;
  assign out_valid        = out_valid_r;
  assign out_data         = out_word_r;

endmodule

`default_nettype wire
